/* hdl/ied_pkg.sv */
package ied_pkg;

	// Width of the coordinates that are actually used; the upper bits of each
	// 32-bit field are ignored. Legal range is 8 to 32.
	localparam int COORD_WIDTH = 32;

	// Fixed field widths of the words on the ports.
	localparam int FIELD_W = 32;
	localparam int DIST_W  = 32;

	// Sum of two squares of coordinate magnitudes.
	localparam int SUM_W = 2 * COORD_WIDTH + 1;

	// Sums at or above 2^LIMIT_BITS are reported as overflow.
	localparam int LIMIT_BITS = 63;

	// Radicand is an even number of bits; it never needs more than 64 bits
	// because larger sums are flagged as overflow.
	localparam int RAD_W  = (2 * COORD_WIDTH + 2 > 64) ? 64 : 2 * COORD_WIDTH + 2;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	// Registers from an accepted word to its result strobe: four front-end
	// stages plus one square-root cell per root bit.
	localparam int LATENCY = 4 + ROOT_W;

	typedef struct packed {
		logic signed [FIELD_W-1:0] first_x;
		logic signed [FIELD_W-1:0] first_y;
		logic signed [FIELD_W-1:0] second_x;
		logic signed [FIELD_W-1:0] second_y;
	} ied_in_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} ied_out_t;

	// Word handed from one square-root cell to the next.
	typedef struct packed {
		logic              valid;
		logic              ovf;
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} ied_cell_t;

endpackage

/* hdl/ied_front.sv */
module ied_front
	import ied_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  ied_in_t   operands,
	output ied_cell_t head
);

	localparam int W = COORD_WIDTH;

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [W:0] dx_s1, dy_s1;
	logic [W-1:0]      mx_s2, my_s2;
	logic [2*W-1:0]    sqx_s3, sqy_s3;
	logic              ovf_s4;
	logic [RAD_W-1:0]  rad_s4;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W:0]    sum_wide;
	logic signed [W:0] x1, y1, x2, y2;
	logic [W:0]        nx, ny;

	// Sign-extend the used low bits of each coordinate by one bit so that the
	// difference cannot wrap.
	assign x1 = signed'({operands.first_x[W-1],  operands.first_x[W-1:0]});
	assign y1 = signed'({operands.first_y[W-1],  operands.first_y[W-1:0]});
	assign x2 = signed'({operands.second_x[W-1], operands.second_x[W-1:0]});
	assign y2 = signed'({operands.second_y[W-1], operands.second_y[W-1:0]});

	assign nx = -dx_s1;
	assign ny = -dy_s1;

	assign sum      = SUM_W'(sqx_s3) + SUM_W'(sqy_s3);
	assign sum_wide = {1'b0, sum};

	// The first cell starts from an empty remainder and an empty root.
	assign head = '{valid: valid_s4, ovf: ovf_s4, rad: rad_s4, rem: '0, root: '0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= x1 - x2;
		dy_s1 <= y1 - y2;
		// The magnitude of a difference always fits in the coordinate width.
		mx_s2 <= dx_s1[W] ? nx[W-1:0] : dx_s1[W-1:0];
		my_s2 <= dy_s1[W] ? ny[W-1:0] : dy_s1[W-1:0];
		sqx_s3 <= (2*W)'(mx_s2) * (2*W)'(mx_s2);
		sqy_s3 <= (2*W)'(my_s2) * (2*W)'(my_s2);
		ovf_s4 <= |(sum >> LIMIT_BITS);
		rad_s4 <= sum_wide[RAD_W-1:0];
	end

endmodule

/* hdl/ied_sqrt_cell.sv */
module ied_sqrt_cell
	import ied_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ied_cell_t cell_in,
	output ied_cell_t cell_s1
);

	logic [REM_W+1:0]  acc;
	logic [REM_W+1:0]  trial;
	logic [REM_W+1:0]  diff;
	logic              ge;
	logic              valid_s1;
	logic              ovf_s1;
	logic [RAD_W-1:0]  rad_s1;
	logic [REM_W-1:0]  rem_s1;
	logic [ROOT_W-1:0] root_s1;

	// One restoring step: bring down the next two radicand bits and try to
	// append a one to the partial root.
	assign acc   = {cell_in.rem, cell_in.rad[RAD_W-1 -: 2]};
	assign trial = (REM_W+2)'({cell_in.root, 2'b01});
	assign ge    = (acc >= trial);
	assign diff  = acc - trial;

	assign cell_s1 = '{valid: valid_s1, ovf: ovf_s1, rad: rad_s1, rem: rem_s1, root: root_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cell_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		ovf_s1  <= cell_in.ovf;
		rad_s1  <= {cell_in.rad[RAD_W-3:0], 2'b00};
		rem_s1  <= ge ? diff[REM_W-1:0] : acc[REM_W-1:0];
		root_s1 <= {cell_in.root[ROOT_W-2:0], ge};
	end

endmodule

/* hdl/integer_euclidean_distance.sv */
// Channel    Handshake              Word
// ---------  ---------------------  -------------------------------------------
// operands   start high, busy low   first_x, first_y, second_x, second_y
// result     done high, one cycle   distance, overflow
//
// A word can be started in every clock cycle; busy is always low because
// nothing inside the block ever has to hold a word back.
// Each result passes from its start through four front-end stages and one
// square-root cell per bit of the root (ROOT_W cells, 32 at 32-bit
// coordinates).
// The asynchronous reset clears only the valid bits along the pipeline.
// The receiver cannot stall; every result is shown for one cycle only.
module integer_euclidean_distance
	import ied_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  ied_in_t  operands,
	output logic     done,
	output ied_out_t result
);

	// chain[0] comes from the front end, chain[k+1] is the output of cell k.
	ied_cell_t chain [ROOT_W+1];

	// The block is fully pipelined, so it is always ready for another word.
	assign busy = 1'b0;

	// The front end forms the coordinate differences, their magnitudes, the
	// two squares and their sum, and flags sums that do not fit in 63 bits.
	ied_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (start),
		.operands (operands),
		.head     (chain[0])
	);

	// A row of identical cells takes the integer square root, one root bit
	// per cell, most significant bit first. Each cell hands its remainder,
	// partial root and the unused radicand bits to its neighbor.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
		ied_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_in (chain[k]),
			.cell_s1 (chain[k+1])
		);
	end

	// An overflowing sum reports a distance of zero.
	assign done            = chain[ROOT_W].valid;
	assign result.overflow = chain[ROOT_W].ovf;
	assign result.distance = chain[ROOT_W].ovf ? '0 : DIST_W'(chain[ROOT_W].root);

endmodule

/* hdl/ied_checker.sv */
module ied_checker
	import ied_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input ied_out_t result
);

	// Every started word yields its result once it has passed the whole pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("started word produced no result at the expected cycle");

	// No result without a start that fed it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result strobe without a matching start");

	// Overflow forces the distance to zero.
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.overflow |-> result.distance == '0)
		else $error("distance not zero on overflow");

	// The root of a 63-bit sum never exceeds floor(sqrt(2^63 - 1)).
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.distance <= DIST_W'(64'd3037000499))
		else $error("distance out of range");

endmodule

bind integer_euclidean_distance ied_checker u_ied_checker (.*);

/* bench/tb_integer_euclidean_distance.sv */
`timescale 1ns / 1ps

module tb_integer_euclidean_distance;
	import ied_pkg::*;

	localparam int N_DIRECTED = 21;
	localparam int N_RANDOM   = 630;

	// Largest sum of squares that still gives a root; one more is overflow.
	localparam logic [67:0] SUM_MAX = 68'h7FFF_FFFF_FFFF_FFFF;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	ied_in_t  operands;
	logic     done;
	ied_out_t result;

	integer_euclidean_distance dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operands (operands),
		.done     (done),
		.result   (result)
	);

	always #6 clk = ~clk;

	// Results still owed by the block, oldest first. The block never holds a
	// word back, so every accepted word adds exactly one entry here.
	ied_out_t pending_distances[$];

	int error_count      = 0;
	int words_sent       = 0;
	int results_checked  = 0;
	int overflow_results = 0;
	int large_roots      = 0;

	// One row of the directed table. Where known is set, the answer columns
	// hold a value that can be worked out by hand; otherwise the predictor
	// supplies the answer.
	typedef struct {
		logic [31:0] x1;
		logic [31:0] y1;
		logic [31:0] x2;
		logic [31:0] y2;
		bit          known;
		logic [31:0] distance;
		bit          ovf;
	} directed_row_t;

	directed_row_t directed_rows [N_DIRECTED] = '{
		// Same point at the origin, and the plain 3-4-5 triangle both ways.
		'{32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0},
		'{32'd0, 32'd0, 32'd3, 32'd4, 1'b1, 32'd5, 1'b0},
		'{-32'sd3, -32'sd4, 32'd0, 32'd0, 1'b1, 32'd5, 1'b0},
		// Roots that are not exact must round down; a unit gap gives exactly one.
		'{32'd0, 32'd0, 32'd1, 32'd1, 1'b1, 32'd1, 1'b0},
		'{32'd0, 32'd0, 32'd2, 32'd2, 1'b1, 32'd2, 1'b0},
		'{32'd1, 32'd0, 32'd0, 32'd0, 1'b1, 32'd1, 1'b0},
		// Identical points at the corners of the coordinate range.
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'd0, 1'b0},
		'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'd0, 1'b0},
		// Opposite corners: far past the 63-bit limit.
		'{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'd0, 1'b1},
		// One axis alone overflows.
		'{32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd0, 1'b1, 32'd0, 1'b1},
		// Each square is 2^62 and fits; only their sum of 2^63 overflows.
		'{32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1},
		// A root of 2^31 must come out unsigned, on either axis.
		'{32'h8000_0000, 32'd0, 32'd0, 32'd0, 1'b1, 32'h8000_0000, 1'b0},
		'{32'd0, 32'h8000_0000, 32'd0, 32'd0, 1'b1, 32'h8000_0000, 1'b0},
		// Largest root that fits, and one step beyond it.
		'{-32'sd1518500250, 32'd0, 32'd1518500249, 32'd0, 1'b1, 32'd3037000499, 1'b0},
		'{32'd0, 32'd1518500249, 32'd0, -32'sd1518500250, 1'b1, 32'd3037000499, 1'b0},
		'{-32'sd1518500250, 32'd0, 32'd1518500250, 32'd0, 1'b1, 32'd0, 1'b1},
		// A sum above the limit, one just below it, and ordinary mixed signs.
		'{32'h8000_0000, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0},
		'{32'd12345, -32'sd67890, -32'sd54321, 32'd98765, 1'b0, 32'd0, 1'b0},
		// Alternating bit patterns toggle every input bit.
		'{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'd0, 1'b0}
	};

	// Floor of the square root of a 64-bit value, one root bit at a time
	// from the top: keep a bit if the trial root squared does not pass n.
	function automatic logic [31:0] floor_root(logic [63:0] n);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (64'(trial) * 64'(trial) <= n)
				root = trial;
		end
		return root;
	endfunction

	// Only the low COORD_WIDTH bits of a field count, read as a signed value.
	function automatic logic signed [63:0] coord_value(logic [FIELD_W-1:0] raw);
		logic signed [63:0] v;
		v = $signed({32'd0, raw}) <<< (64 - COORD_WIDTH);
		return v >>> (64 - COORD_WIDTH);
	endfunction

	// The distance the block should report for one word of operands.
	function automatic ied_out_t floor_distance(ied_in_t w);
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		logic [63:0]        ax;
		logic [63:0]        ay;
		logic [67:0]        sum_sq;
		ied_out_t           r;
		dx = coord_value(w.first_x) - coord_value(w.second_x);
		dy = coord_value(w.first_y) - coord_value(w.second_y);
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		sum_sq = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay);
		if (sum_sq > SUM_MAX) begin
			r.distance = '0;
			r.overflow = 1'b1;
		end else begin
			r.distance = floor_root(sum_sq[63:0]);
			r.overflow = 1'b0;
		end
		return r;
	endfunction

	// A coordinate drawn from one of several regions: anything at all, near
	// zero, the corners of the range, or up to a quarter of the range.
	function automatic logic [31:0] rand_coord();
		logic [31:0] v;
		case ($urandom_range(0, 4))
			0: begin
				v = 32'($urandom_range(0, 2000)) - 32'd1000;
			end
			1: begin
				case ($urandom_range(0, 3))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'd0;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			2: begin
				v = $urandom_range(0, 32'h4000_0000);
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			default: begin
				v = $urandom;
			end
		endcase
		return v;
	endfunction

	// A point pair whose sum of squares lands right at the 63-bit limit:
	// pick the x gap, then the y gap that just fits, nudged by one either
	// way. This is where the root is largest and rounding is tightest.
	function automatic ied_in_t near_limit_pair();
		logic [63:0]        ax;
		logic [63:0]        ay;
		logic signed [63:0] lo_x;
		logic signed [63:0] lo_y;
		logic [31:0]        tmp;
		ied_in_t            w;
		ax = 64'($urandom_range(0, 32'd3037000499));
		ay = 64'(floor_root(64'h7FFF_FFFF_FFFF_FFFF - ax * ax));
		case ($urandom_range(0, 2))
			0: if (ay != 0) ay = ay - 1;
			1: ay = ay + 1;
			default: ;
		endcase
		// Center each gap on zero so both ends fit in 32 bits.
		lo_x = -$signed(ax >> 1);
		lo_y = -$signed(ay >> 1);
		w.first_x  = lo_x[31:0];
		w.second_x = 32'(lo_x + $signed(ax));
		w.first_y  = lo_y[31:0];
		w.second_y = 32'(lo_y + $signed(ay));
		if ($urandom_range(0, 1) == 1) begin
			tmp = w.first_x;
			w.first_x = w.second_x;
			w.second_x = tmp;
		end
		if ($urandom_range(0, 1) == 1) begin
			tmp = w.first_y;
			w.first_y = w.second_y;
			w.second_y = tmp;
		end
		if ($urandom_range(0, 1) == 1) begin
			w = '{first_x: w.first_y, first_y: w.first_x,
			      second_x: w.second_y, second_y: w.second_x};
		end
		return w;
	endfunction

	// Mostly back to back, often a short gap, now and then a long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Hold start low for an idle gap of length n. The operands carry noise meanwhile, which
	// the block must ignore.
	task automatic hold_idle(int n);
		repeat (n) begin
			@(negedge clk);
			start    <= 1'b0;
			operands <= {$urandom, $urandom, $urandom, $urandom};
		end
	endtask

	// Present one word and wait for the edge that takes it. The expected
	// result is queued at that very edge.
	task automatic send_word(ied_in_t w, ied_out_t answer);
		@(negedge clk);
		start    <= 1'b1;
		operands <= w;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_distances.push_back(answer);
		words_sent++;
	endtask

	// Stop sending until every outstanding result has come back.
	task automatic drain_results();
		hold_idle(1);
		while (pending_distances.size() != 0)
			@(posedge clk);
	endtask

	// Result checker. Outputs are sampled at the rising edge, before the
	// block updates them, so each strobe is seen exactly once.
	always @(posedge clk) begin
		ied_out_t want;
		if (done) begin
			if (pending_distances.size() == 0) begin
				$error("result strobe with no word outstanding: distance %0d, overflow %0b",
				       result.distance, result.overflow);
				error_count++;
			end else begin
				want = pending_distances.pop_front();
				results_checked++;
				if (result.distance !== want.distance) begin
					$error("distance: expected %0d, got %0d", want.distance, result.distance);
					error_count++;
				end
				if (result.overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
					error_count++;
				end
				if (want.overflow)
					overflow_results++;
				if (want.distance > 32'h7FFF_FFFF)
					large_roots++;
			end
		end
	end

	initial begin
		ied_in_t  w;
		ied_out_t answer;
		int       gap;

		clk      = 1'b0;
		arst_n   = 1'b0;
		start    = 1'b0;
		operands = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Hand-worked answers are only valid at full width;
		// at a narrower coordinate width every row goes through the predictor.
		for (int i = 0; i < N_DIRECTED; i++) begin
			w = '{first_x: directed_rows[i].x1, first_y: directed_rows[i].y1,
			      second_x: directed_rows[i].x2, second_y: directed_rows[i].y2};
			if (directed_rows[i].known && COORD_WIDTH == FIELD_W) begin
				answer.distance = directed_rows[i].distance;
				answer.overflow = directed_rows[i].ovf;
			end else begin
				answer = floor_distance(w);
			end
			if (i % 5 == 4)
				hold_idle($urandom_range(1, 3));
			send_word(w, answer);
		end

		// Let the whole pipeline empty once before the random part.
		drain_results();

		// Random part. Every fourth block of 40 words is sent back to back
		// so the pipeline runs completely full for a while.
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(0, 9) < 3) begin
				w = near_limit_pair();
			end else begin
				w.first_x  = rand_coord();
				w.first_y  = rand_coord();
				w.second_x = rand_coord();
				w.second_y = rand_coord();
			end
			gap = ((i / 40) % 4 == 3) ? 0 : gap_length();
			if ($urandom_range(0, 99) == 0)
				drain_results();
			hold_idle(gap);
			send_word(w, floor_distance(w));
		end

		drain_results();
		// Run on past the pipeline depth to catch any stray strobe.
		repeat (LATENCY + 4) @(posedge clk);

		$display("Sent %0d words (%0d directed, %0d random) and checked %0d results.",
		         words_sent, N_DIRECTED, N_RANDOM, results_checked);
		$display("Of those, %0d reported overflow and %0d had roots above 2^31-1.",
		         overflow_results, large_roots);
		if (error_count == 0 && pending_distances.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog. A correct run needs well under a tenth of this.
	initial begin
		#(400_000 * 12);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
